FILE: design/rcc_pkg.sv
`default_nettype none
package rcc_pkg;

    localparam int WINDOW_LEN_DEF     = 5;
    localparam int QUALIFY_FRAMES_DEF = 10;
    localparam int STICK_BITS_DEF     = 12;

    localparam int CMD_W  = 16;
    localparam int REG_W  = 15;
    localparam int LIM_W  = 17;
    localparam int NREG   = 8;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_FLIGHT_MODE    = 3'd0,
        REG_ANGLE_LIMIT    = 3'd1,
        REG_RATE_LIMIT     = 3'd2,
        REG_YAW_RATE_LIMIT = 3'd3,
        REG_THRUST_LOW     = 3'd4,
        REG_THRUST_HIGH    = 3'd5,
        REG_HOVER_THROTTLE = 3'd6,
        REG_DEAD_ZONE_HALF = 3'd7
    } reg_index_t;

    // What a frame does to the link state.
    typedef enum logic [1:0] {
        FK_HOLD = 2'd0,
        FK_PROC = 2'd1,
        FK_DROP = 2'd2
    } frame_kind_t;

endpackage
`default_nettype wire

FILE: design/rc_command_conditioner_unit.sv
`default_nettype none
// Channel  | Direction | Contents (lowest bits first)
// s_*      | in        | tdata: roll, pitch, throttle, yaw, arm, mode sticks; tuser: present
// m_*      | out       | tdata: roll, pitch, yaw, throttle cmd; tuser: link, armed, alt, dz
// cfg_*    | in        | register write, index and 15-bit data
// One word enters per cycle while the output register is not stalled; each result passes
// through the four-stage mapping lanes and then the median/flag output stage.
// Reset clears counters, flags, median windows and valid bits; config returns to defaults.
// The whole pipeline halts only while a result waits in the output register.
module rc_command_conditioner_unit #(
    parameter int WINDOW_LEN     = rcc_pkg::WINDOW_LEN_DEF,
    parameter int QUALIFY_FRAMES = rcc_pkg::QUALIFY_FRAMES_DEF,
    parameter int STICK_BITS     = rcc_pkg::STICK_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // roll, pitch, throttle, yaw, arm, mode sticks, STICK_BITS each
    input  wire logic [((6*STICK_BITS+7)/8)*8-1:0] s_tdata,
    // throttle_present
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd
    output logic [63:0]                            m_tdata,
    // link_up, armed_flag, altitude_hold_flag, in_dead_zone
    output logic [3:0]                             m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [rcc_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [rcc_pkg::REG_W-1:0]         cfg_data
);
    import rcc_pkg::*;

    localparam int B    = STICK_BITS;
    localparam int SMAX = (1 << B) - 1;
    localparam int CW   = $clog2(QUALIFY_FRAMES + 1);
    localparam int NST  = 4;

    logic                 flight_mode_reg;
    logic [REG_W-1:0]     angle_limit_reg, rate_limit_reg, yaw_limit_reg;
    logic [REG_W-1:0]     thrust_low_reg, thrust_high_reg, hover_reg, half_reg;

    logic [CW-1:0]        present_count_reg, present_count_next;
    logic [CW-1:0]        absent_count_reg, absent_count_next;
    frame_kind_t          kind_in;

    logic                 v_reg    [NST];
    frame_kind_t          kind_reg [NST];
    logic [B-1:0]         arm_d_reg  [NST];
    logic [B-1:0]         mode_d_reg [NST];

    logic                 link_reg, armed_reg, alt_reg, dz_reg;
    logic                 m_tvalid_reg;
    logic [63:0]          m_tdata_reg;

    logic                 en, acc, win_en;
    logic [B-1:0]         roll_s, pitch_s, thr_s, yaw_s;
    logic signed [LIM_W-1:0] rp, yl, tl, th;
    logic signed [CMD_W-1:0] roll_m, pitch_m, yaw_m, thr_m;
    logic signed [CMD_W-1:0] roll_f, pitch_f, yaw_f, thr_f;
    logic signed [B:0]    arm_f, mode_f;
    logic signed [LIM_W:0] dz_lo, dz_hi;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;

    assign roll_s  = s_tdata[0*B +: B];
    assign pitch_s = s_tdata[1*B +: B];
    assign thr_s   = s_tdata[2*B +: B];
    assign yaw_s   = s_tdata[3*B +: B];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_mode_reg <= 1'b0;
            angle_limit_reg <= 15'd7680;
            rate_limit_reg  <= 15'd23040;
            yaw_limit_reg   <= 15'd23040;
            thrust_low_reg  <= 15'd0;
            thrust_high_reg <= 15'd256;
            hover_reg       <= 15'd128;
            half_reg        <= 15'd13;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FLIGHT_MODE:    flight_mode_reg <= cfg_data[0];
                REG_ANGLE_LIMIT:    angle_limit_reg <= cfg_data;
                REG_RATE_LIMIT:     rate_limit_reg  <= cfg_data;
                REG_YAW_RATE_LIMIT: yaw_limit_reg   <= cfg_data;
                REG_THRUST_LOW:     thrust_low_reg  <= cfg_data;
                REG_THRUST_HIGH:    thrust_high_reg <= cfg_data;
                REG_HOVER_THROTTLE: hover_reg       <= cfg_data;
                REG_DEAD_ZONE_HALF: half_reg        <= cfg_data;
                default:            flight_mode_reg <= flight_mode_reg;
            endcase
        end
    end

    // Link qualification is decided as the word is accepted.
    always_comb
    begin
        present_count_next = present_count_reg;
        absent_count_next  = absent_count_reg;
        kind_in            = FK_HOLD;
        if (s_tuser[0])
        begin
            if (present_count_reg < CW'(QUALIFY_FRAMES))
                present_count_next = present_count_reg + CW'(1);
            else
            begin
                absent_count_next = '0;
                kind_in           = FK_PROC;
            end
        end
        else if (absent_count_reg < CW'(QUALIFY_FRAMES))
            absent_count_next = absent_count_reg + CW'(1);
        else
        begin
            absent_count_next  = '0;
            present_count_next = '0;
            kind_in            = FK_DROP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_count_reg <= '0;
            absent_count_reg  <= '0;
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i]    <= 1'b0;
                kind_reg[i] <= FK_HOLD;
            end
        end
        else
        begin
            if (acc)
            begin
                present_count_reg <= present_count_next;
                absent_count_reg  <= absent_count_next;
            end
            if (en)
            begin
                v_reg[0]    <= s_tvalid;
                kind_reg[0] <= kind_in;
                for (int i = 1; i < NST; i++)
                begin
                    v_reg[i]    <= v_reg[i-1];
                    kind_reg[i] <= kind_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arm_d_reg[0]  <= s_tdata[4*B +: B];
            mode_d_reg[0] <= s_tdata[5*B +: B];
            for (int i = 1; i < NST; i++)
            begin
                arm_d_reg[i]  <= arm_d_reg[i-1];
                mode_d_reg[i] <= mode_d_reg[i-1];
            end
        end
    end

    assign rp = flight_mode_reg ? $signed({2'b00, rate_limit_reg})
                                : $signed({2'b00, angle_limit_reg});
    assign yl = $signed({2'b00, yaw_limit_reg});
    assign tl = $signed({2'b00, thrust_low_reg});
    assign th = $signed({2'b00, thrust_high_reg});

    rcc_map_lane #(.STICK_BITS(B)) u_roll (
        .clk(clk), .en(en), .stick(roll_s), .lo(-rp), .hi(rp), .negate(1'b0), .cmd(roll_m)
    );
    rcc_map_lane #(.STICK_BITS(B)) u_pitch (
        .clk(clk), .en(en), .stick(pitch_s), .lo(-rp), .hi(rp), .negate(1'b1), .cmd(pitch_m)
    );
    rcc_map_lane #(.STICK_BITS(B)) u_yaw (
        .clk(clk), .en(en), .stick(yaw_s), .lo(-yl), .hi(yl), .negate(1'b1), .cmd(yaw_m)
    );
    rcc_map_lane #(.STICK_BITS(B)) u_thr (
        .clk(clk), .en(en), .stick(thr_s), .lo(tl), .hi(th), .negate(1'b0), .cmd(thr_m)
    );

    assign win_en = en && v_reg[NST-1] && (kind_reg[NST-1] == FK_PROC);

    rcc_median #(.DW(CMD_W), .LEN(WINDOW_LEN)) u_med_roll (
        .clk(clk), .rst_n(rst_n), .en(win_en), .din(roll_m), .med(roll_f)
    );
    rcc_median #(.DW(CMD_W), .LEN(WINDOW_LEN)) u_med_pitch (
        .clk(clk), .rst_n(rst_n), .en(win_en), .din(pitch_m), .med(pitch_f)
    );
    rcc_median #(.DW(CMD_W), .LEN(WINDOW_LEN)) u_med_yaw (
        .clk(clk), .rst_n(rst_n), .en(win_en), .din(yaw_m), .med(yaw_f)
    );
    rcc_median #(.DW(CMD_W), .LEN(WINDOW_LEN)) u_med_thr (
        .clk(clk), .rst_n(rst_n), .en(win_en), .din(thr_m), .med(thr_f)
    );
    rcc_median #(.DW(B + 1), .LEN(WINDOW_LEN)) u_med_arm (
        .clk(clk), .rst_n(rst_n), .en(win_en),
        .din($signed({1'b0, arm_d_reg[NST-1]})), .med(arm_f)
    );
    rcc_median #(.DW(B + 1), .LEN(WINDOW_LEN)) u_med_mode (
        .clk(clk), .rst_n(rst_n), .en(win_en),
        .din($signed({1'b0, mode_d_reg[NST-1]})), .med(mode_f)
    );

    assign dz_lo = $signed({3'b000, hover_reg}) - $signed({3'b000, half_reg});
    assign dz_hi = $signed({3'b000, hover_reg}) + $signed({3'b000, half_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            link_reg     <= 1'b0;
            armed_reg    <= 1'b0;
            alt_reg      <= 1'b0;
            dz_reg       <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= v_reg[NST-1];
            if (v_reg[NST-1])
            begin
                if (kind_reg[NST-1] == FK_PROC)
                begin
                    link_reg  <= 1'b1;
                    // Dead zone follows the hold flag from before this word.
                    if (alt_reg)
                        dz_reg <= (dz_lo < (LIM_W+1)'(thr_f)) && ((LIM_W+1)'(thr_f) <= dz_hi);
                    armed_reg <= ((B+2)'(arm_f) <<< 1) > (B+2)'(SMAX);
                    alt_reg   <= ((B+2)'(mode_f) <<< 1) > (B+2)'(SMAX);
                end
                else if (kind_reg[NST-1] == FK_DROP)
                    link_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v_reg[NST-1])
        begin
            if (kind_reg[NST-1] == FK_PROC)
                m_tdata_reg <= {thr_f, yaw_f, pitch_f, roll_f};
            else
                m_tdata_reg <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {dz_reg, alt_reg, armed_reg, link_reg};

    a_zero_without_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("commands nonzero while link is down");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        present_count_reg <= CW'(QUALIFY_FRAMES) && absent_count_reg <= CW'(QUALIFY_FRAMES))
        else $error("qualify counter out of range");

    a_dz_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dz_reg) |-> $past(alt_reg))
        else $error("dead zone set without altitude hold");

    a_window_only_when_proc: assert property (@(posedge clk) disable iff (!rst_n)
        win_en |=> m_tvalid && m_tuser[0])
        else $error("processed word did not raise link");

endmodule
`default_nettype wire

FILE: design/rcc_map_lane.sv
`default_nettype none
module rcc_map_lane #(
    parameter int STICK_BITS = rcc_pkg::STICK_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [STICK_BITS-1:0]                stick,
    input  wire logic signed [rcc_pkg::LIM_W-1:0]     lo,
    input  wire logic signed [rcc_pkg::LIM_W-1:0]     hi,
    input  wire logic                                 negate,
    output logic signed [rcc_pkg::CMD_W-1:0]          cmd
);
    import rcc_pkg::*;

    // value = lo + floor((2*s*(hi-lo) + SMAX) / (2*SMAX)); the numerator is
    // biased positive and divided by a reciprocal multiply with one correction.
    localparam int SMAX = (1 << STICK_BITS) - 1;
    localparam int DIV  = 2 * SMAX;
    localparam int K    = 18;
    localparam int PRW  = STICK_BITS + 19;
    localparam int UW   = STICK_BITS + 20;
    localparam int SH   = STICK_BITS + 32;
    localparam int PW   = UW + 32;
    localparam int QW   = 20;
    localparam int VW   = 22;
    localparam longint unsigned BIAS  = longint'(DIV) << K;
    localparam longint unsigned RECIP = (64'd1 << SH) / DIV;

    logic signed [PRW-1:0]   prod1_reg;
    logic signed [LIM_W-1:0] lo1_reg, lo2_reg, lo3_reg;
    logic                    neg1_reg, neg2_reg, neg3_reg;
    logic [PW-1:0]           prod2_reg;
    logic [UW-1:0]           num2_reg;
    logic [QW-1:0]           q3_reg;
    logic signed [CMD_W-1:0] cmd_reg;

    logic signed [LIM_W:0]   span;
    logic signed [UW:0]      num_s;
    logic [UW-1:0]           num;
    logic [31:0]             recip32;
    logic [QW-1:0]           q0;
    logic [UW-1:0]           rem;
    logic signed [VW-1:0]    val;
    logic signed [VW-1:0]    sval;
    logic signed [CMD_W-1:0] sat;

    assign span    = (LIM_W+1)'(hi) - (LIM_W+1)'(lo);
    assign num_s   = ((UW+1)'(prod1_reg) <<< 1) + (UW+1)'(SMAX) + (UW+1)'(BIAS);
    assign num     = num_s[UW-1:0];
    assign recip32 = RECIP[31:0];
    assign q0      = prod2_reg[SH +: QW];
    assign rem     = num2_reg - UW'(q0 * UW'(DIV));
    assign val     = VW'(lo3_reg) + $signed({2'b00, q3_reg}) - VW'(1 << K);
    assign sval    = neg3_reg ? -val : val;

    always_comb
    begin
        if (sval > VW'(32767))
            sat = 16'sh7FFF;
        else if (sval < -VW'(32768))
            sat = -16'sh8000;
        else
            sat = sval[CMD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= PRW'($signed({1'b0, stick})) * PRW'(span);
            lo1_reg   <= lo;
            neg1_reg  <= negate;
            prod2_reg <= PW'(num) * PW'(recip32);
            num2_reg  <= num;
            lo2_reg   <= lo1_reg;
            neg2_reg  <= neg1_reg;
            q3_reg    <= (rem >= UW'(DIV)) ? q0 + QW'(1) : q0;
            lo3_reg   <= lo2_reg;
            neg3_reg  <= neg2_reg;
            cmd_reg   <= sat;
        end
    end

    assign cmd = cmd_reg;

endmodule
`default_nettype wire

FILE: design/rcc_median.sv
`default_nettype none
module rcc_median #(
    parameter int DW  = 16,
    parameter int LEN = rcc_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic signed [DW-1:0] din,
    output logic signed [DW-1:0]      med
);
    import rcc_pkg::*;

    localparam int RW = $clog2(LEN + 1);

    logic signed [DW-1:0] win_reg  [LEN];
    logic signed [DW-1:0] win_next [LEN];
    logic [RW-1:0]        rank     [LEN];

    always_comb
    begin
        win_next[0] = din;
        for (int i = 1; i < LEN; i++)
            win_next[i] = win_reg[i-1];
    end

    // Ties are ranked by position so every entry gets a distinct rank.
    always_comb
    begin
        med = win_next[0];
        for (int i = 0; i < LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < LEN; j++)
                if ((win_next[j] < win_next[i]) || (j < i && win_next[j] == win_next[i]))
                    rank[i] = rank[i] + RW'(1);
        end
        for (int i = 0; i < LEN; i++)
            if (rank[i] == RW'(LEN / 2))
                med = win_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEN; i++)
                win_reg[i] <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < LEN; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rcc_pkg::*;

    localparam int SB   = 12;
    localparam int WLEN = 5;
    localparam int QUAL = 10;
    localparam longint SFULL = (1 << SB) - 1;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] thr;
        logic        link;
        logic        armed;
        logic        alt;
        logic        dz;
    } command_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    rc_command_conditioner_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [14:0] regs_q [NREG];
    int          present_cnt;
    int          absent_cnt;
    longint      roll_win [WLEN];
    longint      pitch_win [WLEN];
    longint      yaw_win [WLEN];
    longint      thr_win [WLEN];
    longint      arm_win [WLEN];
    longint      mode_win [WLEN];
    logic        link_f, armed_f, alt_f, dz_f;

    command_t    expected_cmds [$];
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint stick_map(longint s, longint lo, longint hi);
        return lo + div_floor(2 * s * (hi - lo) + SFULL, 2 * SFULL);
    endfunction

    // Shifts a value into a window and returns the window median.
    function automatic longint window_median(ref longint win [WLEN], input longint v);
        longint sorted [WLEN];
        longint t;
        for (int i = WLEN - 1; i > 0; i--)
            win[i] = win[i - 1];
        win[0] = v;
        sorted = win;
        for (int i = 0; i < WLEN; i++)
            for (int j = 0; j < WLEN - 1 - i; j++)
                if (sorted[j] > sorted[j + 1])
                begin
                    t = sorted[j];
                    sorted[j] = sorted[j + 1];
                    sorted[j + 1] = t;
                end
        return sorted[WLEN / 2];
    endfunction

    function automatic command_t condition_frame(logic [SB-1:0] ch [6], logic present);
        command_t c;
        longint rp, yl, r, p, y, th, a, md;
        r = 0; p = 0; y = 0; th = 0;
        if (present)
        begin
            if (present_cnt < QUAL)
                present_cnt++;
            else
            begin
                yl = regs_q[REG_YAW_RATE_LIMIT];
                rp = regs_q[REG_FLIGHT_MODE][0] ? regs_q[REG_RATE_LIMIT]
                                                : regs_q[REG_ANGLE_LIMIT];
                absent_cnt = 0;
                link_f = 1'b1;
                y = window_median(yaw_win, clamp16(-stick_map(ch[3], -yl, yl)));
                th = window_median(thr_win, clamp16(stick_map(ch[2],
                         regs_q[REG_THRUST_LOW], regs_q[REG_THRUST_HIGH])));
                if (alt_f)
                    dz_f = (longint'(regs_q[REG_HOVER_THROTTLE]) -
                            longint'(regs_q[REG_DEAD_ZONE_HALF]) < th) &&
                           (th <= longint'(regs_q[REG_HOVER_THROTTLE]) +
                            longint'(regs_q[REG_DEAD_ZONE_HALF]));
                a = window_median(arm_win, ch[4]);
                armed_f = (2 * a > SFULL);
                md = window_median(mode_win, ch[5]);
                alt_f = (2 * md > SFULL);
                r = window_median(roll_win, clamp16(stick_map(ch[0], -rp, rp)));
                p = window_median(pitch_win, clamp16(-stick_map(ch[1], -rp, rp)));
            end
        end
        else if (absent_cnt < QUAL)
            absent_cnt++;
        else
        begin
            link_f = 1'b0;
            absent_cnt = 0;
            present_cnt = 0;
        end
        c.roll = r[15:0];
        c.pitch = p[15:0];
        c.yaw = y[15:0];
        c.thr = th[15:0];
        c.link = link_f;
        c.armed = armed_f;
        c.alt = alt_f;
        c.dz = dz_f;
        return c;
    endfunction

    // Valid stays high between back-to-back words and drops only while idling.
    task automatic send_frame(logic [SB-1:0] ch [6], logic present);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ch[5], ch[4], ch[3], ch[2], ch[1], ch[0]};
        s_tuser <= present;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_cmds.push_back(condition_frame(ch, present));
        words_sent++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [14:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        regs_q[idx] = (idx == REG_FLIGHT_MODE) ? {14'd0, value[0]} : value;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_all_regs(logic [14:0] v [NREG]);
        for (int i = 0; i < NREG; i++)
            write_reg(reg_index_t'(i), v[i]);
        cfg_we <= 1'b0;
    endtask

    // Random frame, biased toward a present link so the filters stay busy.
    task automatic send_random_frame(int absent_pct);
        logic [SB-1:0] ch [6];
        for (int i = 0; i < 6; i++)
        begin
            case ($urandom_range(5))
                0: ch[i] = '0;
                1: ch[i] = '1;
                2: ch[i] = SB'(12'd2047 + $urandom_range(1));
                default: ch[i] = SB'($urandom);
            endcase
        end
        send_frame(ch, $urandom_range(99) >= absent_pct);
    endtask

    task automatic test_directed;
        logic [SB-1:0] ch [6];
        // Qualify the link, then drive extremes.
        for (int k = 0; k < 22; k++)
        begin
            for (int i = 0; i < 6; i++)
                ch[i] = (k % 3 == 0) ? '0 : (k % 3 == 1) ? '1 : 12'h800;
            if (k == 20)
                ch = '{12'h555, 12'hAAA, 12'h7FF, 12'h801, 12'h800, 12'h801};
            send_frame(ch, 1'b1);
        end
        // Loss of signal: three absent frames, fewer than it takes for the link to drop.
        for (int k = 0; k < 3; k++)
            send_frame(ch, 1'b0);
        drain();
    endtask

    task automatic test_config_phase(logic [14:0] v [NREG], int n, int absent_pct);
        write_all_regs(v);
        for (int k = 0; k < n; k++)
            send_random_frame(absent_pct);
        drain();
    endtask

    task automatic test_link_loss;
        logic [SB-1:0] ch [6];
        ch = '{12'd100, 12'd4000, 12'd3000, 12'd2049, 12'd4095, 12'd4095};
        for (int k = 0; k < 15; k++)
            send_frame(ch, 1'b1);
        for (int k = 0; k < 12; k++)
            send_frame(ch, 1'b0);
        for (int k = 0; k < 14; k++)
            send_frame(ch, 1'b1);
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        command_t got, exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                   m_tuser[0], m_tuser[1], m_tuser[2], m_tuser[3]};
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word: %h", got);
            end
            else
            begin
                exp_c = expected_cmds.pop_front();
                words_checked++;
                if (got !== exp_c)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch word %0d: roll %0d/%0d pitch %0d/%0d",
                                 words_checked,
                                 $signed(exp_c.roll), $signed(got.roll),
                                 $signed(exp_c.pitch), $signed(got.pitch),
                                 " yaw %0d/%0d thr %0d/%0d flags %b/%b",
                                 $signed(exp_c.yaw), $signed(got.yaw),
                                 $signed(exp_c.thr), $signed(got.thr),
                                 {exp_c.link, exp_c.armed, exp_c.alt, exp_c.dz},
                                 {got.link, got.armed, got.alt, got.dz});
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAIL rc_command_conditioner_unit");
        $finish;
    end

    initial
    begin
        logic [14:0] v [NREG];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        regs_q = '{15'd0, 15'd7680, 15'd23040, 15'd23040, 15'd0, 15'd256, 15'd128, 15'd13};
        present_cnt = 0;
        absent_cnt = 0;
        for (int i = 0; i < WLEN; i++)
        begin
            roll_win[i] = 0; pitch_win[i] = 0; yaw_win[i] = 0;
            thr_win[i] = 0; arm_win[i] = 0; mode_win[i] = 0;
        end
        {link_f, armed_f, alt_f, dz_f} = 4'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();

        send_idle_pct = 65;
        recv_stall_pct = 0;
        v = '{15'd1, 15'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0, 15'd16384, 15'd2000};
        test_config_phase(v, 200, 5);

        send_idle_pct = 0;
        recv_stall_pct = 65;
        v = '{15'd0, 15'h7FFF, 15'd0, 15'd0, 15'd0, 15'h7FFF, 15'd0, 15'h7FFF};
        test_config_phase(v, 200, 5);

        send_idle_pct = 22;
        recv_stall_pct = 22;
        v = '{15'd1, 15'd1234, 15'd5000, 15'd300, 15'd200, 15'd900, 15'd500, 15'd60};
        test_config_phase(v, 250, 15);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_link_loss();
        for (int i = 0; i < NREG; i++)
            v[i] = 15'($urandom);
        test_config_phase(v, 300, 8);

        $display("Sent %0d frames across five register settings and four idling mixes;",
                 words_sent);
        $display("checked %0d conditioned command words, %0d mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("PASS rc_command_conditioner_unit");
        else
            $display("FAIL rc_command_conditioner_unit");
        $finish;
    end

endmodule

FILE: sim.f
design/rcc_pkg.sv
design/rcc_map_lane.sv
design/rcc_median.sv
design/rc_command_conditioner_unit.sv
tb/sv/testbench.sv
